>>> sv/bfci_pkg.sv
package bfci_pkg;

  // Array depth in bytes and the index width it implies.
  localparam int FLASH_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(FLASH_DEPTH);

  // Field widths fixed by the bus and the configuration registers.
  localparam int ADDR_IN_W = 20;
  localparam int SIZE_W    = 18;
  localparam int SHIFT_W   = 4;
  localparam int ID_W      = 16;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // Width of the fill walker: covers the array size, the size register and
  // the largest erase block past the end of the array.
  localparam int WALK_W = ((ADDR_W > 16) ? ADDR_W : 16) + 2;
  localparam int CMP_W  = (WALK_W > ADDR_IN_W) ? WALK_W : ADDR_IN_W;

  typedef logic [WALK_W-1:0] walk_t;

  // Command bytes.
  localparam logic [7:0] CMD_ALT_PROGRAM   = 8'h10;
  localparam logic [7:0] CMD_ERASE_SETUP   = 8'h20;
  localparam logic [7:0] CMD_PROGRAM       = 8'h40;
  localparam logic [7:0] CMD_STATUS_CLEAR  = 8'h50;
  localparam logic [7:0] CMD_STATUS_READ   = 8'h70;
  localparam logic [7:0] CMD_ID_READ       = 8'h90;
  localparam logic [7:0] CMD_ERASE_SUSPEND = 8'hB0;
  localparam logic [7:0] CMD_ERASE_CONFIRM = 8'hD0;
  localparam logic [7:0] CMD_ARRAY_READ    = 8'hFF;

  localparam logic [7:0] STATUS_ERRORS = 8'h30;
  localparam logic [7:0] ERASED_BYTE   = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID   = 2'd2;

  // Request to the fill walker: write the erased byte from first to last.
  typedef struct packed {
    logic  start;
    walk_t first;
    walk_t last;
  } fill_req_t;

endpackage

>>> sv/byte_flash_command_interface.sv
// Byte-wide flash array behind a two-write command interface.
//
// Bus requests arrive on start/operation/address/write_data and are taken at
// a clock edge where start is high and busy is low. A write request updates
// the command state, programs one byte or launches a block erase; it gives
// no result. A read request gives exactly one result: read_data is shown for
// one cycle with read_valid high, after the request has passed the read
// state and the result register. The receiver cannot stall, so results
// never back up.
//
// A write leaves busy low unless it launches a block erase. A read holds
// busy high while it is in the read state. A block erase keeps busy high
// while the fill walker walks the 2**block_shift bytes of its block, one
// byte per cycle; the walker is the one unit that writes the erased byte.
//
// After reset the same walker clears all 131072 bytes of the array to 0xFF,
// one byte a cycle; busy is high throughout. Configuration writes on
// cfg_valid/cfg_index/cfg_data are always ready and are taken at any time,
// but should be made only while no request is in flight.
module byte_flash_command_interface (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              operation,
  input  logic [bfci_pkg::ADDR_IN_W-1:0]    address,
  input  logic [bfci_pkg::DATA_W-1:0]       write_data,
  output logic                              read_valid,
  output logic [bfci_pkg::DATA_W-1:0]       read_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfci_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import bfci_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SIZE_W-1:0]  flash_size;
  logic [SHIFT_W-1:0] block_shift;
  logic [ID_W-1:0]    device_id;

  // Command state.
  logic [7:0] current_command;
  logic       second_cycle;
  logic [7:0] status_byte;

  // Read path: whether the result comes from the array, or else the byte
  // chosen when the request was taken.
  logic              rd_from_mem;
  logic [DATA_W-1:0] rd_byte;

  logic              accept;
  logic              walk_busy;
  logic [DATA_W-1:0] mem_q;
  walk_t             limit;
  walk_t             size_ext;
  walk_t             blk_mask;
  walk_t             blk_base;
  logic              in_range;
  fill_req_t         fill;
  logic              prog_en;
  logic              rd_en;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE) || walk_busy;

  // The array in use is the smaller of the size register and the memory.
  assign size_ext = WALK_W'(flash_size);
  assign limit    = (size_ext > WALK_W'(FLASH_DEPTH)) ? WALK_W'(FLASH_DEPTH) : size_ext;
  assign in_range = CMP_W'(address) < CMP_W'(limit);

  // An in-range address fits the array index, so the block base does too.
  assign blk_mask = (WALK_W'(1) << block_shift) - WALK_W'(1);
  assign blk_base = WALK_W'(address[ADDR_W-1:0]) & ~blk_mask;

  assign fill.start = accept && operation && second_cycle &&
                      (current_command == CMD_ERASE_SETUP) &&
                      (write_data == CMD_ERASE_CONFIRM) && in_range;
  assign fill.first = blk_base;
  assign fill.last  = blk_base | blk_mask;

  assign prog_en = accept && operation && second_cycle && in_range &&
                   ((current_command == CMD_PROGRAM) ||
                    (current_command == CMD_ALT_PROGRAM));
  assign rd_en   = accept && !operation;

  bfci_array u_array (
    .clk       (clk),
    .rst       (rst),
    .fill      (fill),
    .limit     (limit),
    .prog_en   (prog_en),
    .prog_addr (address[ADDR_W-1:0]),
    .prog_data (write_data),
    .rd_en     (rd_en),
    .rd_addr   (address[ADDR_W-1:0]),
    .rd_data   (mem_q),
    .walk_busy (walk_busy)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_size  <= SIZE_W'(FLASH_DEPTH);
      block_shift <= 4'd12;
      device_id   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FLASH_SIZE:  flash_size  <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_SHIFT: block_shift <= cfg_data[SHIFT_W-1:0];
        REG_DEVICE_ID:   device_id   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decoding. A command write picks the mode; a program or an
  // erase setup arms the write that follows, which performs or rejects it.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= CMD_ARRAY_READ;
      second_cycle    <= 1'b0;
      status_byte     <= '0;
    end else if (accept && operation) begin
      if (!second_cycle) begin
        case (write_data)
          CMD_ARRAY_READ, CMD_STATUS_READ, CMD_ERASE_SUSPEND, CMD_ID_READ: begin
            current_command <= write_data;
          end
          CMD_STATUS_CLEAR: begin
            status_byte     <= '0;
            current_command <= CMD_ARRAY_READ;
          end
          CMD_PROGRAM, CMD_ALT_PROGRAM, CMD_ERASE_SETUP: begin
            current_command <= write_data;
            second_cycle    <= 1'b1;
          end
          default: ;
        endcase
      end else begin
        second_cycle <= 1'b0;
        // Anything but a confirm after an erase setup is a sequence error.
        if ((current_command == CMD_ERASE_SETUP) &&
            (write_data != CMD_ERASE_CONFIRM)) begin
          current_command <= CMD_STATUS_READ;
          status_byte     <= status_byte | STATUS_ERRORS;
        end
      end
    end
  end

  // Read sequencing: the array registers its byte when the request is taken,
  // and in the read state the result and the strobe are registered together.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      read_valid <= 1'b0;
    end else begin
      read_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (rd_en) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          read_valid <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_from_mem <= (current_command == CMD_ARRAY_READ) && in_range;
      if (current_command == CMD_STATUS_READ) begin
        rd_byte <= status_byte;
      end else if (current_command == CMD_ID_READ) begin
        rd_byte <= address[0] ? device_id[15:8] : device_id[7:0];
      end else begin
        rd_byte <= ERASED_BYTE;
      end
    end
    if (state == ST_READ) begin
      read_data <= rd_from_mem ? mem_q : rd_byte;
    end
  end

  // A result strobe only ever follows the read state.
  a_strobe_after_read: assert property (@(posedge clk) disable iff (rst)
    read_valid |-> $past(state == ST_READ))
    else $error("read strobe without a read in progress");

  // A taken read always enters the read state on the next cycle.
  a_read_enters_state: assert property (@(posedge clk) disable iff (rst)
    (accept && !operation) |=> (state == ST_READ))
    else $error("read request did not enter the read state");

  // The second write cycle always closes the two-write sequence.
  a_second_cycle_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && operation && second_cycle) |=> !second_cycle)
    else $error("second cycle flag not cleared");

  // A launched erase holds off new requests on the following cycle.
  a_erase_blocks: assert property (@(posedge clk) disable iff (rst)
    fill.start |=> busy)
    else $error("erase launched without raising busy");

  // The armed flag may be set only for a program or erase setup command.
  a_armed_command: assert property (@(posedge clk) disable iff (rst)
    second_cycle |-> ((current_command == CMD_PROGRAM) ||
                      (current_command == CMD_ALT_PROGRAM) ||
                      (current_command == CMD_ERASE_SETUP)))
    else $error("second cycle armed for a one-cycle command");

endmodule

>>> sv/bfci_array.sv
module bfci_array (
  input  logic                            clk,
  input  logic                            rst,
  input  bfci_pkg::fill_req_t             fill,
  input  bfci_pkg::walk_t                 limit,
  input  logic                            prog_en,
  input  logic [bfci_pkg::ADDR_W-1:0]     prog_addr,
  input  logic [bfci_pkg::DATA_W-1:0]     prog_data,
  input  logic                            rd_en,
  input  logic [bfci_pkg::ADDR_W-1:0]     rd_addr,
  output logic [bfci_pkg::DATA_W-1:0]     rd_data,
  output logic                            walk_busy
);
  import bfci_pkg::*;

  logic [DATA_W-1:0] mem [FLASH_DEPTH];

  walk_t ptr;
  walk_t last;
  logic  active;
  logic  clear_mode;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  // The walker owns the write port while it runs. During the clearing pass
  // every entry is written; during an erase only entries below the limit.
  always_comb begin
    if (active) begin
      wr_en   = clear_mode || (ptr < limit);
      wr_addr = ptr[ADDR_W-1:0];
      wr_data = ERASED_BYTE;
    end else begin
      wr_en   = prog_en;
      wr_addr = prog_addr;
      wr_data = prog_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b1;
      clear_mode <= 1'b1;
      ptr        <= '0;
      last       <= WALK_W'(FLASH_DEPTH - 1);
    end else if (active) begin
      if (ptr == last) begin
        active     <= 1'b0;
        clear_mode <= 1'b0;
      end else begin
        ptr <= ptr + WALK_W'(1);
      end
    end else if (fill.start) begin
      active <= 1'b1;
      ptr    <= fill.first;
      last   <= fill.last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign walk_busy = active;

endmodule
